// File: rtl/tcw_pkg.sv
// tcw_pkg: shared types, codes and constants of the text console window engine
// no dependencies; imported by tcw_ctrl, tcw_dp and text_console_window_engine
package tcw_pkg;

  // default store geometry
  localparam int COLS_DEF = 64;
  localparam int ROWS_DEF = 32;

  // coordinate and character widths of the request fields
  localparam int XW = 7;
  localparam int YW = 6;
  localparam int CW = 8;

  // character codes
  localparam logic [CW-1:0] SPACE_CODE   = 8'd32;
  localparam logic [CW-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CW-1:0] RETURN_CODE  = 8'd13;

  // opcodes
  localparam logic [2:0] OP_PUT      = 3'd0;
  localparam logic [2:0] OP_CARET    = 3'd1;
  localparam logic [2:0] OP_WINDOW   = 3'd2;
  localparam logic [2:0] OP_CLEAR    = 3'd3;
  localparam logic [2:0] OP_RECT     = 3'd4;
  localparam logic [2:0] OP_FILL_ALL = 3'd5;
  localparam logic [2:0] OP_READ     = 3'd6;

  // request payload
  typedef struct packed {
    logic [2:0]    opcode;
    logic [CW-1:0] char_code;
    logic [XW-1:0] first_x;
    logic [YW-1:0] first_y;
    logic [XW-1:0] last_x;
    logic [YW-1:0] last_y;
  } req_t;

  // result payload
  typedef struct packed {
    logic [5:0]    caret_col;
    logic [4:0]    caret_row;
    logic [CW-1:0] cell_value;
    logic          did_scroll;
  } res_t;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_FILL,
    S_COPY_RD,
    S_COPY_WR,
    S_TAIL,
    S_READ
  } state_t;

  // datapath commands
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_EXEC,
    CMD_FILL,
    CMD_COPY_RD,
    CMD_COPY_WR,
    CMD_TAIL,
    CMD_READ
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       put_scroll;
    logic       fill_empty;
    logic       copy_empty;
    logic       walk_last;
  } status_t;

endpackage

// File: rtl/tcw_ctrl.sv
// tcw_ctrl: sequencer of the console engine; steps the datapath through each request
// depends on tcw_pkg
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output logic    busy,
  output cmd_t    cmd
);

  state_t state, state_next;

  // state register, starts with the store clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (status.walk_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (status.op)
          OP_PUT: begin
            if (!status.put_scroll) state_next = S_IDLE;
            else if (status.copy_empty) state_next = S_TAIL;
            else state_next = S_COPY_RD;
          end
          OP_CLEAR, OP_RECT, OP_FILL_ALL: begin
            state_next = status.fill_empty ? S_IDLE : S_FILL;
          end
          OP_READ: state_next = S_READ;
          default: state_next = S_IDLE;
        endcase
      end
      S_FILL: begin
        if (status.walk_last) state_next = S_IDLE;
      end
      S_COPY_RD: state_next = S_COPY_WR;
      S_COPY_WR: begin
        state_next = status.walk_last ? S_TAIL : S_COPY_RD;
      end
      S_TAIL: state_next = S_FILL;
      S_READ: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd.op     = CMD_NONE;
    cmd.finish = 1'b0;
    busy       = (state != S_IDLE);
    case (state)
      S_CLEAR: cmd.op = CMD_FILL;
      S_IDLE: begin
        if (start) cmd.op = CMD_LOAD;
      end
      S_EXEC: begin
        cmd.op     = CMD_EXEC;
        cmd.finish = (state_next == S_IDLE);
      end
      S_FILL: begin
        cmd.op     = CMD_FILL;
        cmd.finish = status.walk_last;
      end
      S_COPY_RD: cmd.op = CMD_COPY_RD;
      S_COPY_WR: cmd.op = CMD_COPY_WR;
      S_TAIL:    cmd.op = CMD_TAIL;
      S_READ: begin
        cmd.op     = CMD_READ;
        cmd.finish = 1'b1;
      end
      default: cmd.op = CMD_NONE;
    endcase
  end

endmodule

// File: rtl/tcw_dp.sv
// tcw_dp: datapath of the console engine: character store, caret, window and area walker
// depends on tcw_pkg; driven by commands from tcw_ctrl
module tcw_dp
  import tcw_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
)(
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  input  req_t    request,
  output status_t status,
  output logic    done,
  output res_t    result
);

  localparam int AXW   = $clog2(COLS);
  localparam int AYW   = $clog2(ROWS);
  localparam int AW    = AXW + AYW;
  localparam int DEPTH = ROWS * (2 ** AXW);

  localparam logic [XW-1:0] COLS_X = XW'(COLS);
  localparam logic [XW-1:0] XMAX   = XW'(COLS - 1);
  localparam logic [YW-1:0] ROWS_Y = YW'(ROWS);
  localparam logic [YW-1:0] YMAX   = YW'(ROWS - 1);

  function automatic logic [AW-1:0] cell_addr(input logic [YW-1:0] y, input logic [XW-1:0] x);
    return {y[AYW-1:0], x[AXW-1:0]};
  endfunction

  function automatic logic [XW-1:0] clamp_x(input logic [XW-1:0] v,
                                            input logic [XW-1:0] lo,
                                            input logic [XW-1:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [YW-1:0] clamp_y(input logic [YW-1:0] v,
                                            input logic [YW-1:0] lo,
                                            input logic [YW-1:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // latched request
  req_t r;

  // caret and window
  logic [XW-1:0] cur_col, win_l, win_r;
  logic [YW-1:0] cur_row, win_t, win_b;

  // area walker shared by fills and the scroll copy
  logic [XW-1:0] wx, x0, x1;
  logic [YW-1:0] wy, y1;
  logic [CW-1:0] fch;

  // result registers
  logic          scrolled, rd_ok;
  logic [CW-1:0] rd_char;

  // store
  logic [CW-1:0] mem [DEPTH];
  logic [CW-1:0] rdata;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [CW-1:0] wdata;

  // put: caret step
  logic [XW:0]   col_inc;
  logic [XW-1:0] put_col_n;
  logic [YW-1:0] put_row_n;
  logic          put_scroll, put_write;

  always_comb begin
    col_inc    = {1'b0, cur_col} + (XW+1)'(1);
    put_write  = 1'b0;
    put_col_n  = win_l;
    put_row_n  = cur_row;
    if (r.char_code == NEWLINE_CODE) begin
      put_row_n = cur_row + YW'(1);
    end else if (r.char_code == RETURN_CODE) begin
      put_row_n = cur_row;
    end else begin
      put_write = 1'b1;
      if (col_inc >= {1'b0, win_r}) begin
        put_row_n = cur_row + YW'(1);
      end else begin
        put_col_n = col_inc[XW-1:0];
      end
    end
    put_scroll = (put_row_n >= win_b);
  end

  // rectangle bounds clipped to the store
  logic [XW-1:0] rx1;
  logic [YW-1:0] ry1;

  always_comb begin
    rx1 = (r.last_x > COLS_X) ? COLS_X : r.last_x;
    ry1 = (r.last_y > ROWS_Y) ? ROWS_Y : r.last_y;
  end

  // new window bounds, never empty
  logic [XW-1:0] nwl, nwr;
  logic [YW-1:0] nwt, nwb;

  always_comb begin
    nwl = (r.first_x > XMAX) ? XMAX : r.first_x;
    nwt = (r.first_y > YMAX) ? YMAX : r.first_y;
    nwr = (rx1 <= nwl) ? nwl + XW'(1) : rx1;
    nwb = (ry1 <= nwt) ? nwt + YW'(1) : ry1;
  end

  // walker step
  logic [XW:0] wx_inc;
  logic [YW:0] wy_inc;
  logic        row_end;

  always_comb begin
    wx_inc  = {1'b0, wx} + (XW+1)'(1);
    wy_inc  = {1'b0, wy} + (YW+1)'(1);
    row_end = (wx_inc >= {1'b0, x1});
  end

  // status to the controller
  always_comb begin
    status.op         = r.opcode;
    status.put_scroll = put_scroll;
    status.fill_empty = (r.opcode == OP_RECT) && ((r.first_x >= rx1) || (r.first_y >= ry1));
    status.copy_empty = ({1'b0, win_t} + (YW+1)'(1)) >= {1'b0, win_b};
    status.walk_last  = row_end && (wy_inc >= {1'b0, y1});
  end

  // store port selection
  always_comb begin
    we    = 1'b0;
    waddr = cell_addr(wy, wx);
    wdata = fch;
    raddr = cell_addr(wy_inc[YW-1:0], wx);
    case (cmd.op)
      CMD_EXEC: begin
        raddr = cell_addr(r.first_y, r.first_x);
        if (r.opcode == OP_PUT && put_write) begin
          we    = 1'b1;
          waddr = cell_addr(cur_row, cur_col);
          wdata = r.char_code;
        end
      end
      CMD_FILL: we = 1'b1;
      CMD_COPY_WR: begin
        we    = 1'b1;
        wdata = rdata;
      end
      default: we = 1'b0;
    endcase
  end

  // character store
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  // caret, window, walker and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
      win_l   <= '0;
      win_t   <= '0;
      win_r   <= COLS_X;
      win_b   <= ROWS_Y;
      wx      <= '0;
      wy      <= '0;
      x0      <= '0;
      x1      <= COLS_X;
      y1      <= ROWS_Y;
      fch     <= SPACE_CODE;
    end else begin
      case (cmd.op)
        CMD_LOAD: r <= request;
        CMD_EXEC: begin
          scrolled <= 1'b0;
          rd_char  <= '0;
          rd_ok    <= (r.first_x < COLS_X) && (r.first_y < ROWS_Y);
          case (r.opcode)
            OP_PUT: begin
              cur_col  <= put_col_n;
              cur_row  <= put_scroll ? win_b - YW'(1) : put_row_n;
              scrolled <= put_scroll;
              wx       <= win_l;
              wy       <= win_t;
              x0       <= win_l;
              x1       <= win_r;
              y1       <= win_b - YW'(1);
            end
            OP_CARET: begin
              cur_col <= clamp_x(r.first_x, win_l, win_r - XW'(1));
              cur_row <= clamp_y(r.first_y, win_t, win_b - YW'(1));
            end
            OP_WINDOW: begin
              win_l   <= nwl;
              win_t   <= nwt;
              win_r   <= nwr;
              win_b   <= nwb;
              cur_col <= clamp_x(cur_col, nwl, nwr - XW'(1));
              cur_row <= clamp_y(cur_row, nwt, nwb - YW'(1));
            end
            OP_CLEAR: begin
              wx  <= win_l;
              wy  <= win_t;
              x0  <= win_l;
              x1  <= win_r;
              y1  <= win_b;
              fch <= SPACE_CODE;
            end
            OP_RECT: begin
              wx  <= r.first_x;
              wy  <= r.first_y;
              x0  <= r.first_x;
              x1  <= rx1;
              y1  <= ry1;
              fch <= r.char_code;
            end
            OP_FILL_ALL: begin
              wx  <= '0;
              wy  <= '0;
              x0  <= '0;
              x1  <= COLS_X;
              y1  <= ROWS_Y;
              fch <= r.char_code;
            end
            default: ;
          endcase
        end
        CMD_FILL, CMD_COPY_WR: begin
          if (row_end) begin
            wx <= x0;
            wy <= wy_inc[YW-1:0];
          end else begin
            wx <= wx_inc[XW-1:0];
          end
        end
        CMD_TAIL: begin
          wx  <= win_l;
          wy  <= win_b - YW'(1);
          y1  <= win_b;
          fch <= SPACE_CODE;
        end
        CMD_READ: rd_char <= rd_ok ? rdata : '0;
        default: ;
      endcase
    end
  end

  // result fields
  always_comb begin
    result.caret_col  = cur_col[5:0];
    result.caret_row  = cur_row[4:0];
    result.cell_value = rd_char;
    result.did_scroll = scrolled;
  end

endmodule

// File: rtl/text_console_window_engine.sv
// text_console_window_engine: top level of the character-cell console with scrolling window
// depends on tcw_pkg, tcw_ctrl and tcw_dp
//
// Usage:
//   A request (opcode, char_code, first_x/y, last_x/y) is taken at a rising edge
//   where start is high and busy is low. Every request returns one result
//   (caret_col, caret_row, cell_value, did_scroll) on the result port for exactly
//   one cycle, flagged by done; the receiver always takes it.
//   Put without scroll, set caret, set window and the empty rectangle fill are
//   done in the execute state; read cell adds a read state after it. Fills write
//   one cell per cycle in the fill state. A scroll copies each cell with a read
//   state and a write state through the single store read port, then blanks the
//   bottom row of the window.
//   The result strobe is registered and comes in the cycle after the last store
//   write; a new request may be taken in that same cycle.
//   Reset: the caret goes home, the window spans the whole store, and the store
//   is swept to spaces, one cell per cycle, with busy high, before the first
//   request is taken.
module text_console_window_engine
  import tcw_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
)(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output res_t result
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  tcw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // store, caret and window
  tcw_dp #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .status  (status),
    .done    (done),
    .result  (result)
  );

`ifndef NO_ASSERTIONS
  // the store clearing sweep holds off requests right after reset
  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("request port open right after reset");

  // an accepted request keeps the engine busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("engine not busy after accepting a request");

  // only a put can scroll
  a_scroll_only_put: assert property (@(posedge clk) disable iff (rst)
    done && result.did_scroll |-> status.op == OP_PUT)
    else $error("scroll reported for an opcode other than put");

  // cell value is zero unless the request was a read
  a_cell_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status.op != OP_READ) |-> result.cell_value == '0)
    else $error("nonzero cell value for an opcode other than read");
`endif

endmodule
